FILE: hdl/tsq_pkg.sv
`default_nettype none

package tsq_pkg;

  // Default geometry of the two stacks.
  localparam int unsigned StackDepthDefault = 1024;
  localparam int unsigned ValueBitsDefault  = 20;

  // Result field widths that the interface fixes.
  localparam int unsigned StatusBits = 2;
  localparam int unsigned CostBits   = 12;

  // Largest cost that the cost field can carry.
  localparam logic [CostBits-1:0] CostMax = '1;

  // Result status codes.
  typedef enum logic [StatusBits-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Operation codes carried in the input tuser bit.
  localparam logic FUNC_ENQUEUE = 1'b0;
  localparam logic FUNC_DEQUEUE = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_XFER   = 3'b010,
    S_RESULT = 3'b100
  } state_e;

endpackage

`default_nettype wire

FILE: hdl/two_stack_queue_with_cost_top.sv
`default_nettype none

// Channel   Direction  Handshake                     tuser    tdata (lowest bit up)
// s_axis    in         s_axis_tvalid/s_axis_tready   func     item_value, zero pad
// m_axis    out        m_axis_tvalid/m_axis_tready   -        status, out_value,
//                                                             cost_units, zero pad
//
// An enqueue is written from idle; a plain dequeue or an empty or overflow result goes to
// the result state. A dequeue finding the outbound stack empty first reads its n inbound
// entries one per cycle via the read port, moving all but the bottom one, which it pops.
// Reset clears both stack counts and the sequencer; memory contents are not cleared.
// Input is taken only while the sequencer is idle; a held result stalls the sequencer
// only once the next result has to be loaded and the output side is not ready.
module two_stack_queue_with_cost_top
  import tsq_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = StackDepthDefault,
  parameter int unsigned VALUE_BITS  = ValueBitsDefault,
  localparam int unsigned InW  = ((VALUE_BITS + 7) / 8) * 8,
  localparam int unsigned OutW = ((StatusBits + VALUE_BITS + CostBits + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic            s_axis_tuser,   // func
  input  wire logic [InW-1:0]  s_axis_tdata,   // item_value, zero pad
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [OutW-1:0]      m_axis_tdata    // status, out_value, cost_units, zero pad
);

  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  // Stack storage and registered read data.
  logic [VALUE_BITS-1:0] in_mem  [STACK_DEPTH];
  logic [VALUE_BITS-1:0] out_mem [STACK_DEPTH];
  logic [VALUE_BITS-1:0] in_rdata_q, out_rdata_q;

  // Control state.
  state_e          state_q, state_d;
  logic [CntW-1:0] in_cnt_q, in_cnt_d;
  logic [CntW-1:0] out_cnt_q, out_cnt_d;
  logic            rd_pend_q, rd_pend_d;
  status_e         res_status_q, res_status_d;
  logic            res_from_in_q, res_from_in_d;
  logic [CostBits-1:0] res_cost_q, res_cost_d;

  // Output register.
  logic                  m_valid_q, m_valid_d;
  status_e               m_status_q, m_status_d;
  logic [VALUE_BITS-1:0] m_value_q, m_value_d;
  logic [CostBits-1:0]   m_cost_q, m_cost_d;

  // Memory port controls.
  logic             in_we, in_re, out_we, out_re;
  logic [AddrW-1:0] in_waddr, in_raddr, out_waddr, out_raddr;

  logic                  s_accept;
  logic                  out_free;
  logic [CntW:0]         xfer_cost;
  logic [VALUE_BITS-1:0] item_value;

  assign item_value = s_axis_tdata[VALUE_BITS-1:0];
  assign s_accept   = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_valid_q || m_axis_tready;

  // Transfer cost is two per inbound entry plus one for the final pop.
  assign xfer_cost = {in_cnt_q, 1'b1};

  // Sequencer and memory access control.
  always_comb begin
    state_d       = state_q;
    in_cnt_d      = in_cnt_q;
    out_cnt_d     = out_cnt_q;
    rd_pend_d     = rd_pend_q;
    res_status_d  = res_status_q;
    res_from_in_d = res_from_in_q;
    res_cost_d    = res_cost_q;
    m_valid_d     = m_valid_q && !m_axis_tready;
    m_status_d    = m_status_q;
    m_value_d     = m_value_q;
    m_cost_d      = m_cost_q;
    in_we         = 1'b0;
    in_re         = 1'b0;
    out_we        = 1'b0;
    out_re        = 1'b0;
    in_waddr      = in_cnt_q[AddrW-1:0];
    in_raddr      = AddrW'(in_cnt_q - CntOne);
    out_waddr     = out_cnt_q[AddrW-1:0];
    out_raddr     = AddrW'(out_cnt_q - CntOne);
    s_axis_tready = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          if (s_axis_tuser == FUNC_ENQUEUE) begin
            if (in_cnt_q == CntFull) begin
              res_status_d = ST_OVERFLOW;
              state_d      = S_RESULT;
            end else begin
              in_we    = 1'b1;
              in_cnt_d = in_cnt_q + CntOne;
            end
          end else if (out_cnt_q != '0) begin
            // Plain pop from the outbound stack.
            out_re        = 1'b1;
            out_cnt_d     = out_cnt_q - CntOne;
            res_status_d  = ST_OK;
            res_from_in_d = 1'b0;
            res_cost_d    = CostBits'(1);
            state_d       = S_RESULT;
          end else if (in_cnt_q == '0) begin
            res_status_d = ST_EMPTY;
            state_d      = S_RESULT;
          end else begin
            // Move the inbound stack across before popping.
            res_status_d  = ST_OK;
            res_from_in_d = 1'b1;
            res_cost_d    = (xfer_cost > (CntW + 1)'(CostMax)) ? CostMax
                                                               : CostBits'(xfer_cost);
            rd_pend_d     = 1'b0;
            state_d       = S_XFER;
          end
        end
      end
      S_XFER: begin
        // Write the entry read last cycle onto the outbound stack.
        if (rd_pend_q) begin
          out_we    = 1'b1;
          out_cnt_d = out_cnt_q + CntOne;
        end
        // The bottom inbound entry is the popped value and is not written back.
        in_re     = 1'b1;
        in_cnt_d  = in_cnt_q - CntOne;
        rd_pend_d = (in_cnt_q != CntOne);
        if (in_cnt_q == CntOne) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          if (res_status_q == ST_OK) begin
            m_value_d = res_from_in_q ? in_rdata_q : out_rdata_q;
            m_cost_d  = res_cost_q;
          end else begin
            m_value_d = '0;
            m_cost_d  = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Inbound stack memory.
  always_ff @(posedge clk_i) begin
    if (in_we) begin
      in_mem[in_waddr] <= item_value;
    end
    if (in_re) begin
      in_rdata_q <= in_mem[in_raddr];
    end
  end

  // Outbound stack memory.
  always_ff @(posedge clk_i) begin
    if (out_we) begin
      out_mem[out_waddr] <= in_rdata_q;
    end
    if (out_re) begin
      out_rdata_q <= out_mem[out_raddr];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      rd_pend_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      rd_pend_q <= rd_pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    res_status_q  <= res_status_d;
    res_from_in_q <= res_from_in_d;
    res_cost_q    <= res_cost_d;
    m_status_q    <= m_status_d;
    m_value_q     <= m_value_d;
    m_cost_q      <= m_cost_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutW'({m_cost_q, m_value_q, m_status_q});

  // Neither stack count ever runs past the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_cnt_q <= CntFull) && (out_cnt_q <= CntFull))
    else $error("stack count beyond depth");

  // A transfer only runs with inbound entries left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XFER) |-> (in_cnt_q != '0))
    else $error("transfer with empty inbound stack");

  // A transfer starts only into an empty outbound stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_XFER && !rd_pend_q) |-> (out_cnt_q == '0))
    else $error("transfer into non-empty outbound stack");

  // An empty status is only reported while both stacks are empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && res_status_q == ST_EMPTY)
      |-> (in_cnt_q == '0 && out_cnt_q == '0))
    else $error("empty status with entries held");

endmodule

`default_nettype wire
